FILE: rtl/core/tbt_pkg.sv
// Package for the thermistor beta temperature unit.
// Holds the configuration register indexes, fixed-point constants, stage bundles
// and the log2 table generator. No dependencies.
package tbt_pkg;

	typedef enum logic [2:0] {
		CFG_DIVIDER_MODE   = 3'd0,
		CFG_SERIES_OHMS    = 3'd1,
		CFG_SUPPLY_MV      = 3'd2,
		CFG_ADC_FULL_SCALE = 3'd3,
		CFG_BETA_VALUE     = 3'd4,
		CFG_NOMINAL_OHMS   = 3'd5
	} cfg_index_t;

	localparam logic [23:0] RES_MAX       = 24'd16777215;
	localparam logic [23:0] LN2_Q24       = 24'd11629080;
	localparam logic [14:0] T25_CENTI     = 15'd29815;
	localparam logic [21:0] BETA_T_SCALE  = 22'd2981500;
	localparam logic [6:0]  CENTI         = 7'd100;
	localparam logic [15:0] KELVIN_CENTI  = 16'd27315;
	localparam logic [15:0] TC_LIMIT      = 16'd60082;
	localparam logic signed [15:0] TEMP_MAX      = 16'sd32767;
	localparam logic signed [15:0] TEMP_ABS_ZERO = -16'sd27315;

	typedef struct packed {
		logic [63:0] x;
		logic [5:0]  c;
	} norm_t;

	typedef struct packed {
		logic [39:0] num;
		logic [15:0] den;
		logic        err;
		logic        numz;
		logic        rovf;
	} front_t;

	typedef struct packed {
		logic [23:0] res;
		logic        err;
		logic        numz;
	} side_t;

	typedef struct packed {
		side_t sd;
		logic  dle0;
		logic  tovf;
	} back_t;

	function automatic logic [31:0] log2_entry(input int unsigned i, input int unsigned b);
		longint unsigned m;
		longint unsigned r;
		r = 0;
		if (i == (32'd1 << b)) begin
			r = 64'd1 << 30;
		end else begin
			m = (64'd1 << 30) + (64'(i) << (30 - b));
			for (int k = 0; k < 30; k++) begin
				m = (m * m) >> 30;
				r = r << 1;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					r = r | 64'd1;
				end
			end
		end
		return r[31:0];
	endfunction

	function automatic norm_t norm_step(input norm_t a, input int unsigned k);
		norm_t r;
		r = a;
		if ((a.x >> (64 - k)) == 64'd0) begin
			r.x = a.x << k;
			r.c = a.c + 6'(k);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/tbt_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
// Expects dividend below divisor shifted up by QBITS. Depends on nothing.
module tbt_div_pipe #(
	parameter int QBITS = 16,
	parameter int DW = 63,
	parameter int VW = 48,
	parameter int SW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [DW-1:0]    dividend,
	input  logic [VW-1:0]    divisor,
	input  logic [SW-1:0]    side_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [QBITS-1:0] quotient,
	output logic [SW-1:0]    side_out
);

	localparam int RW = (DW > VW + QBITS) ? DW : VW + QBITS;

	logic [RW-1:0]    rem_s  [QBITS-1];
	logic [VW-1:0]    dvs_s  [QBITS-1];
	logic [QBITS-1:0] quo_s  [QBITS];
	logic [SW-1:0]    side_s [QBITS];
	logic [QBITS-1:0] v_s;
	logic [QBITS:0]   rdy;

	assign rdy[QBITS] = out_ready;

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		localparam int B = QBITS - 1 - k;
		logic [RW-1:0]    rem_in;
		logic [RW-1:0]    trial;
		logic [VW-1:0]    dvs_in;
		logic [QBITS-1:0] quo_in;
		logic [SW-1:0]    sd_in;
		logic             v_in;
		logic             fits;

		if (k == 0) begin : g_first
			assign rem_in = RW'(dividend);
			assign dvs_in = divisor;
			assign quo_in = '0;
			assign sd_in  = side_in;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
			assign sd_in  = side_s[k-1];
			assign v_in   = v_s[k-1];
		end

		assign trial  = RW'(dvs_in) << B;
		assign fits   = rem_in >= trial;
		assign rdy[k] = !v_s[k] | rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				quo_s[k]  <= fits ? (quo_in | (QBITS'(1) << B)) : quo_in;
				side_s[k] <= sd_in;
			end
		end

		if (k < QBITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					rem_s[k] <= fits ? (rem_in - trial) : rem_in;
					dvs_s[k] <= dvs_in;
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[QBITS-1];
	assign quotient  = quo_s[QBITS-1];
	assign side_out  = side_s[QBITS-1];

endmodule

FILE: rtl/core/thermistor_beta_temperature_unit.sv
// Thermistor beta temperature unit: divider reading to ohms and centi-degrees C.
// A new word is taken every cycle while the output is not stalled, set by the
// one-bit-per-stage dividers (24 and 16 stages) in line.
// A stalled output fills bubbles behind it before the input stops.
// Reset clears all valid bits and loads the configuration registers' defaults.
// Uses tbt_pkg and tbt_div_pipe.
module thermistor_beta_temperature_unit
	import tbt_pkg::*;
#(
	parameter int LOG_TABLE_BITS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        reading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        resistance_ohms,
	output logic signed [15:0] temp_centi_c,
	output logic               range_error
);

	localparam int TAB_LEN = (1 << LOG_TABLE_BITS) + 1;
	localparam int SH = 32 - LOG_TABLE_BITS;
	localparam int IW = LOG_TABLE_BITS + 1;

	logic        mode_q;
	logic [23:0] series_q;
	logic [15:0] supply_q;
	logic [15:0] full_q;
	logic [15:0] beta_q;
	logic [23:0] nominal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			series_q  <= 24'd10000;
			supply_q  <= 16'd3300;
			full_q    <= 16'd4095;
			beta_q    <= 16'd3950;
			nominal_q <= 24'd100000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIVIDER_MODE:   mode_q    <= cfg_data[0];
				CFG_SERIES_OHMS:    series_q  <= cfg_data;
				CFG_SUPPLY_MV:      supply_q  <= cfg_data[15:0];
				CFG_ADC_FULL_SCALE: full_q    <= cfg_data[15:0];
				CFG_BETA_VALUE:     beta_q    <= cfg_data[15:0];
				CFG_NOMINAL_OHMS:   nominal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] log_tab [TAB_LEN];
	for (genvar i = 0; i < TAB_LEN; i++) begin : g_tab
		assign log_tab[i] = log2_entry(i, LOG_TABLE_BITS);
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;
	logic rdy_s9, rdy_s10, rdy_s11, rdy_s12, rdy_s13, rdy_s14, rdy_s15;
	logic diva_in_ready, diva_out_valid, divb_in_ready, divb_out_valid;

	assign rdy_s1  = !v_s1  | rdy_s2;
	assign rdy_s2  = !v_s2  | diva_in_ready;
	assign rdy_s3  = !v_s3  | rdy_s4;
	assign rdy_s4  = !v_s4  | rdy_s5;
	assign rdy_s5  = !v_s5  | rdy_s6;
	assign rdy_s6  = !v_s6  | rdy_s7;
	assign rdy_s7  = !v_s7  | rdy_s8;
	assign rdy_s8  = !v_s8  | rdy_s9;
	assign rdy_s9  = !v_s9  | rdy_s10;
	assign rdy_s10 = !v_s10 | rdy_s11;
	assign rdy_s11 = !v_s11 | rdy_s12;
	assign rdy_s12 = !v_s12 | rdy_s13;
	assign rdy_s13 = !v_s13 | rdy_s14;
	assign rdy_s14 = !v_s14 | divb_in_ready;
	assign rdy_s15 = !v_s15 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1  <= in_valid;
			if (rdy_s2)  v_s2  <= v_s1;
			if (rdy_s3)  v_s3  <= diva_out_valid;
			if (rdy_s4)  v_s4  <= v_s3;
			if (rdy_s5)  v_s5  <= v_s4;
			if (rdy_s6)  v_s6  <= v_s5;
			if (rdy_s7)  v_s7  <= v_s6;
			if (rdy_s8)  v_s8  <= v_s7;
			if (rdy_s9)  v_s9  <= v_s8;
			if (rdy_s10) v_s10 <= v_s9;
			if (rdy_s11) v_s11 <= v_s10;
			if (rdy_s12) v_s12 <= v_s11;
			if (rdy_s13) v_s13 <= v_s12;
			if (rdy_s14) v_s14 <= v_s13;
			if (rdy_s15) v_s15 <= divb_out_valid;
		end
	end

	logic [15:0] limit;
	logic [39:0] num_s1;
	logic [15:0] den_s1;
	logic        err_s1;

	assign limit = mode_q ? full_q : supply_q;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			num_s1 <= reading * series_q;
			den_s1 <= limit - reading;
			err_s1 <= reading >= limit;
		end
	end

	logic [41:0] rdd;
	logic [41:0] rdd_s2;
	logic [16:0] rds_s2;
	front_t      fr_s2;

	assign rdd = {1'b0, num_s1, 1'b0} + 42'(den_s1);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			rdd_s2     <= rdd;
			rds_s2     <= {den_s1, 1'b0};
			fr_s2.num  <= num_s1;
			fr_s2.den  <= den_s1;
			fr_s2.err  <= err_s1;
			fr_s2.numz <= num_s1 == 40'd0;
			fr_s2.rovf <= rdd >= {1'b0, den_s1, 25'd0};
		end
	end

	logic [23:0] qa;
	front_t      fa;

	tbt_div_pipe #(
		.QBITS(24),
		.DW(42),
		.VW(17),
		.SW($bits(front_t))
	) u_res_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s2),
		.in_ready(diva_in_ready),
		.dividend(rdd_s2),
		.divisor(rds_s2),
		.side_in(fr_s2),
		.out_valid(diva_out_valid),
		.out_ready(rdy_s3),
		.quotient(qa),
		.side_out(fa)
	);

	side_t sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8;
	side_t sd_s9, sd_s10, sd_s11, sd_s12, sd_s13;
	norm_t nm_s3 [3];
	norm_t nm_s4 [3];
	norm_t nm_s5 [3];
	norm_t nm_in [3];

	assign nm_in[0] = '{x: 64'(fa.num), c: 6'd0};
	assign nm_in[1] = '{x: 64'(fa.den), c: 6'd0};
	assign nm_in[2] = '{x: 64'(nominal_q), c: 6'd0};

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sd_s3.res  <= (fa.err | fa.rovf) ? RES_MAX : qa;
			sd_s3.err  <= fa.err;
			sd_s3.numz <= fa.numz;
			for (int j = 0; j < 3; j++) begin
				nm_s3[j] <= norm_step(norm_step(nm_in[j], 32), 16);
			end
		end
		if (rdy_s4) begin
			sd_s4 <= sd_s3;
			for (int j = 0; j < 3; j++) begin
				nm_s4[j] <= norm_step(norm_step(nm_s3[j], 8), 4);
			end
		end
		if (rdy_s5) begin
			sd_s5 <= sd_s4;
			for (int j = 0; j < 3; j++) begin
				nm_s5[j] <= norm_step(norm_step(nm_s4[j], 2), 1);
			end
		end
	end

	logic [LOG_TABLE_BITS-1:0] idx [3];
	logic [31:0]               t0_s6 [3];
	logic [31:0]               dt_s6 [3];
	logic [SH-1:0]             rm_s6 [3];
	logic [5:0]                e_s6  [3];
	logic [31:0]               t0_s7 [3];
	logic [31+SH:0]            pr_s7 [3];
	logic [5:0]                e_s7  [3];
	logic [36:0]               lg_s8 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			idx[j] = nm_s5[j].x[62 -: LOG_TABLE_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			sd_s6 <= sd_s5;
			for (int j = 0; j < 3; j++) begin
				t0_s6[j] <= log_tab[IW'(idx[j])];
				dt_s6[j] <= log_tab[IW'(idx[j]) + IW'(1)] - log_tab[IW'(idx[j])];
				rm_s6[j] <= nm_s5[j].x[62-LOG_TABLE_BITS -: SH];
				e_s6[j]  <= 6'd63 - nm_s5[j].c;
			end
		end
		if (rdy_s7) begin
			sd_s7 <= sd_s6;
			for (int j = 0; j < 3; j++) begin
				pr_s7[j] <= dt_s6[j] * rm_s6[j];
				t0_s7[j] <= t0_s6[j];
				e_s7[j]  <= e_s6[j];
			end
		end
		if (rdy_s8) begin
			sd_s8 <= sd_s7;
			for (int j = 0; j < 3; j++) begin
				lg_s8[j] <= {1'b0, e_s7[j], 30'd0} + 37'(t0_s7[j]) + 37'(pr_s7[j] >> SH);
			end
		end
	end

	logic signed [38:0] l2_s9;
	logic [38:0]        l2_abs;
	logic               neg_s10, neg_s11, neg_s12;
	logic [31:0]        ms_s10;
	logic [55:0]        p_s11;
	logic [46:0]        lv_s12;
	logic [37:0]        nb_s12, nb_s13;
	logic [22:0]        bh_s12;
	logic signed [49:0] d_s13;
	logic [47:0]        dd;
	logic [62:0]        tdd_s14;
	logic [47:0]        dd_s14;
	back_t              bk_s14;

	assign l2_abs = l2_s9[38] ? 39'(-l2_s9) : 39'(l2_s9);
	assign dd     = d_s13[47:0];

	always_ff @(posedge clk) begin
		if (rdy_s9) begin
			sd_s9 <= sd_s8;
			l2_s9 <= $signed({2'b0, lg_s8[0]}) - $signed({2'b0, lg_s8[1]})
				- $signed({2'b0, lg_s8[2]});
		end
		if (rdy_s10) begin
			sd_s10  <= sd_s9;
			neg_s10 <= l2_s9[38];
			ms_s10  <= 32'(l2_abs >> 6);
		end
		if (rdy_s11) begin
			sd_s11  <= sd_s10;
			neg_s11 <= neg_s10;
			p_s11   <= ms_s10 * LN2_Q24;
		end
		if (rdy_s12) begin
			sd_s12  <= sd_s11;
			neg_s12 <= neg_s11;
			lv_s12  <= T25_CENTI * p_s11[55:24];
			nb_s12  <= BETA_T_SCALE * beta_q;
			bh_s12  <= CENTI * beta_q;
		end
		if (rdy_s13) begin
			sd_s13 <= sd_s12;
			nb_s13 <= nb_s12;
			d_s13  <= (neg_s12 ? -$signed({3'b0, lv_s12}) : $signed({3'b0, lv_s12}))
				+ $signed({3'b0, bh_s12, 24'd0});
		end
		if (rdy_s14) begin
			bk_s14.sd   <= sd_s13;
			bk_s14.dle0 <= d_s13[49] || (d_s13 == 50'sd0);
			tdd_s14     <= {1'b0, nb_s13, 24'd0} + 63'(dd >> 1);
			bk_s14.tovf <= ({1'b0, nb_s13, 24'd0} + 64'(dd >> 1)) >= {dd, 16'd0};
			dd_s14      <= dd;
		end
	end

	logic [15:0] qb;
	back_t       bb;

	tbt_div_pipe #(
		.QBITS(16),
		.DW(63),
		.VW(48),
		.SW($bits(back_t))
	) u_temp_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s14),
		.in_ready(divb_in_ready),
		.dividend(tdd_s14),
		.divisor(dd_s14),
		.side_in(bk_s14),
		.out_valid(divb_out_valid),
		.out_ready(rdy_s15),
		.quotient(qb),
		.side_out(bb)
	);

	logic signed [15:0] temp_c;
	logic [23:0]        res_s15;
	logic signed [15:0] temp_s15;
	logic               err_s15;

	always_comb begin
		if (bb.sd.err) begin
			temp_c = TEMP_ABS_ZERO;
		end else if (bb.sd.numz) begin
			temp_c = TEMP_MAX;
		end else if (nominal_q == 24'd0) begin
			temp_c = TEMP_ABS_ZERO;
		end else if (bb.dle0 || bb.tovf || (qb >= TC_LIMIT)) begin
			temp_c = TEMP_MAX;
		end else begin
			temp_c = $signed(qb - KELVIN_CENTI);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s15) begin
			res_s15  <= bb.sd.res;
			temp_s15 <= temp_c;
			err_s15  <= bb.sd.err;
		end
	end

	assign in_ready        = rdy_s1;
	assign out_valid       = v_s15;
	assign resistance_ohms = res_s15;
	assign temp_centi_c    = temp_s15;
	assign range_error     = err_s15;

	a_error_word_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> resistance_ohms == RES_MAX && temp_centi_c == TEMP_ABS_ZERO)
		else $error("range error word carries wrong fixed values");

	a_temp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temp_centi_c >= TEMP_ABS_ZERO)
		else $error("temperature below absolute zero");

	a_front_open: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

endmodule
